FILE: rtl/core/mise_pkg.sv
`timescale 1ns / 1ps
package mise_pkg;

  localparam logic [5:0] OP_SPECIAL   = 6'h00;
  localparam logic [5:0] OP_J         = 6'h02;
  localparam logic [5:0] OP_JAL       = 6'h03;
  localparam logic [5:0] OP_BEQ       = 6'h04;
  localparam logic [5:0] OP_BNE       = 6'h05;
  localparam logic [5:0] OP_ADDI      = 6'h08;
  localparam logic [5:0] OP_ADD_IMM_U = 6'h09;

  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;

  typedef enum logic [3:0] {
    K_ADD, K_SUB, K_ADDI, K_MULT, K_DIV, K_DIVU, K_JR, K_MFHI, K_MTHI,
    K_MFLO, K_MTLO, K_BEQ, K_BNE, K_J, K_JAL, K_UNK
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [25:0] imm;
  } dec_t;

  typedef struct packed {
    logic [29:0] fetch_index;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        divide_by_zero;
    logic        unknown_opcode;
  } res_t;

endpackage

FILE: rtl/core/mise_if.sv
`timescale 1ns / 1ps
interface mise_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface mise_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] fetch_index;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        divide_by_zero;
  logic        unknown_opcode;
  modport source (output valid, output fetch_index, output reg_written, output reg_index,
                  output reg_value, output divide_by_zero, output unknown_opcode,
                  input ready);
  modport sink (input valid, input fetch_index, input reg_written, input reg_index,
                input reg_value, input divide_by_zero, input unknown_opcode,
                output ready);
endinterface

FILE: rtl/core/mise_decode.sv
`timescale 1ns / 1ps
module mise_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       instr_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output mise_pkg::dec_t    q_data_o
);
  import mise_pkg::*;

  // Two-entry queue between decode and execute.
  dec_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  dec_t       dec;
  logic [5:0] op, fn;
  logic       push, pop;

  assign op = instr_i[31:26];
  assign fn = instr_i[5:0];

  always_comb begin
    dec.rs = instr_i[25:21];
    dec.rt = instr_i[20:16];
    dec.rd = instr_i[15:11];
    dec.imm = instr_i[25:0];
    dec.kind = K_UNK;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_ADD, FN_ADDU: dec.kind = K_ADD;
          FN_SUB, FN_SUBU: dec.kind = K_SUB;
          FN_MULT: dec.kind = K_MULT;
          FN_DIV: dec.kind = K_DIV;
          FN_DIVU: dec.kind = K_DIVU;
          FN_JR: dec.kind = K_JR;
          FN_MFHI: dec.kind = K_MFHI;
          FN_MTHI: dec.kind = K_MTHI;
          FN_MFLO: dec.kind = K_MFLO;
          FN_MTLO: dec.kind = K_MTLO;
          default: dec.kind = K_UNK;
        endcase
      end
      OP_ADDI, OP_ADD_IMM_U: dec.kind = K_ADDI;
      OP_BEQ: dec.kind = K_BEQ;
      OP_BNE: dec.kind = K_BNE;
      OP_J: dec.kind = K_J;
      OP_JAL: dec.kind = K_JAL;
      default: dec.kind = K_UNK;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/core/mise_div.sv
`timescale 1ns / 1ps
module mise_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);
  // Restoring divider, one quotient bit per cycle.
  logic [31:0] quot_q, rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_q, quot_q[31]};
  assign diff = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quot_q <= {quot_q[30:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        quot_q <= {quot_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o = rem_q;
endmodule

FILE: rtl/core/mise_execute.sv
`timescale 1ns / 1ps
module mise_execute #(
  parameter int REGISTER_COUNT = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  mise_pkg::dec_t q_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mise_pkg::res_t out_data_o
);
  import mise_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_READ = 5'b00010, S_EXEC = 5'b00100,
    S_MUL = 5'b01000, S_DIV = 5'b10000
  } state_e;

  localparam int IW = $clog2(REGISTER_COUNT);

  state_e      state_q;
  logic [31:0] rf_q [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_q;
  logic [31:0] a_q, b_q, hi_q, lo_q, pc_q, npc_q;
  dec_t        d_q;
  res_t        res_q;
  logic        ov_q;
  logic [31:0] a, b, simm, sum, sub, new_npc, wval;
  logic        wen, start_div, div_done, fin, dz;
  logic [4:0]  widx;
  logic [31:0] ma, mb, quot, rem;
  logic        neg_p;
  logic [63:0] prod_q;
  logic        mul_neg_q;

  // Register file entries not yet written read as zero.
  assign a = vld_q[d_q.rs[IW-1:0]] ? a_q : 32'd0;
  assign b = vld_q[d_q.rt[IW-1:0]] ? b_q : 32'd0;
  assign simm = {{16{d_q.imm[15]}}, d_q.imm[15:0]};
  assign sum = a + ((d_q.kind == K_ADDI) ? simm : b);
  assign sub = a - b;
  assign ma = (a[31] && d_q.kind == K_DIV) ? -a : a;
  assign mb = (b[31] && d_q.kind == K_DIV) ? -b : b;
  assign neg_p = a[31] ^ b[31];

  mise_div u_div (
    .clk_i, .rst_ni,
    .start_i(start_div), .dividend_i(ma), .divisor_i(mb),
    .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  assign dz = (b == 32'd0);
  assign start_div = (state_q == S_EXEC) && (d_q.kind == K_DIV || d_q.kind == K_DIVU) && !dz;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i && !ov_q;
  assign fin = (state_q == S_EXEC && !start_div && d_q.kind != K_MULT) ||
               (state_q == S_MUL) || (state_q == S_DIV && div_done);

  always_comb begin
    wen = 1'b0;
    widx = d_q.rd;
    wval = sum;
    new_npc = npc_q + 32'd4;
    case (d_q.kind)
      K_ADD: wen = 1'b1;
      K_SUB: begin wen = 1'b1; wval = sub; end
      K_ADDI: begin wen = 1'b1; widx = d_q.rt; end
      K_MFHI: begin wen = 1'b1; wval = hi_q; end
      K_MFLO: begin wen = 1'b1; wval = lo_q; end
      K_JR: new_npc = a + 32'd4;
      K_BEQ: if (a == b) new_npc = npc_q + 32'd4 + {simm[29:0], 2'b00};
      K_BNE: if (a != b) new_npc = npc_q + 32'd4 + {simm[29:0], 2'b00};
      K_J: new_npc = {npc_q[31:28], d_q.imm, 2'b00} + 32'd4;
      K_JAL: begin
        wen = 1'b1; widx = 5'd31; wval = pc_q + 32'd4;
        new_npc = {npc_q[31:28], d_q.imm, 2'b00} + 32'd4;
      end
      default: ;
    endcase
    if (widx == 5'd0) wen = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      a_q <= rf_q[d_q.rs[IW-1:0]];
      b_q <= rf_q[d_q.rt[IW-1:0]];
    end
    if (state_q == S_EXEC) begin
      prod_q <= {32'd0, (a[31] ? -a : a)} * {32'd0, (b[31] ? -b : b)};
      mul_neg_q <= neg_p;
    end
    if (state_q == S_EXEC && wen) rf_q[widx[IW-1:0]] <= wval;
    if (q_pop_o) d_q <= q_data_i;
    if (fin) begin
      // The program counter has already stepped in the execute cycle.
      res_q.fetch_index <= (state_q == S_EXEC) ? new_npc[31:2] - 30'd1
                                               : npc_q[31:2] - 30'd1;
      res_q.reg_written <= (state_q == S_EXEC) && wen;
      res_q.reg_index <= (state_q == S_EXEC && wen) ? widx : 5'd0;
      res_q.reg_value <= (state_q == S_EXEC && wen) ? wval : 32'd0;
      res_q.divide_by_zero <= (state_q == S_EXEC) &&
                              (d_q.kind == K_DIV || d_q.kind == K_DIVU) && dz;
      res_q.unknown_opcode <= (state_q == S_EXEC) && d_q.kind == K_UNK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q <= '0;
      hi_q <= '0;
      lo_q <= '0;
      pc_q <= 32'd4;
      npc_q <= 32'd4;
      ov_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (fin) ov_q <= 1'b1;
      case (state_q)
        S_IDLE: if (q_pop_o) state_q <= S_READ;
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          if (wen) vld_q[widx[IW-1:0]] <= 1'b1;
          if (d_q.kind == K_MTHI) hi_q <= a;
          if (d_q.kind == K_MTLO) lo_q <= a;
          if (d_q.kind == K_MULT) state_q <= S_MUL;
          else if (start_div) state_q <= S_DIV;
          else state_q <= S_IDLE;
          // Multiply, and divide with a nonzero divisor, step sequentially, finished later.
          pc_q <= npc_q;
          npc_q <= new_npc;
        end
        S_MUL: begin
          {hi_q, lo_q} <= mul_neg_q ? -prod_q : prod_q;
          state_q <= S_IDLE;
        end
        S_DIV: if (div_done) begin
          lo_q <= (d_q.kind == K_DIV && neg_p) ? -quot : quot;
          hi_q <= (d_q.kind == K_DIV && a[31]) ? -rem : rem;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o = res_q;
endmodule

FILE: rtl/core/mips_integer_subset_executor.sv
`timescale 1ns / 1ps
// Executes one MIPS integer instruction per transaction and returns one result per
// instruction. A decode stage classifies each word into a two-entry queue; the execute
// stage steps through queue pop, register file read and execute for each instruction,
// adds a state for mult (registered 32x32 multiply), and for div/divu with a nonzero
// divisor waits on the bit-serial divider. The result is held in an output register, and
// the next instruction is popped only after that result has been taken.
module mips_integer_subset_executor #(
  parameter int REGISTER_COUNT = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  mise_in_if.sink     in_if,
  mise_out_if.source  out_if
);
  import mise_pkg::*;

  logic q_valid, q_pop;
  dec_t q_data;
  res_t res;

  mise_decode u_dec (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .instr_i(in_if.instruction),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  mise_execute #(.REGISTER_COUNT(REGISTER_COUNT)) u_exe (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(res)
  );

  assign out_if.fetch_index = res.fetch_index;
  assign out_if.reg_written = res.reg_written;
  assign out_if.reg_index = res.reg_index;
  assign out_if.reg_value = res.reg_value;
  assign out_if.divide_by_zero = res.divide_by_zero;
  assign out_if.unknown_opcode = res.unknown_opcode;

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_r0_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.reg_written |-> out_if.reg_index != 5'd0)
    else $error("register zero reported as written");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.divide_by_zero && out_if.unknown_opcode))
    else $error("conflicting flags");
endmodule
